// ===== rtl/btne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btne_pkg
// Shared types and constants of the B-tree internal node engine.
// ----------------------------------------------------------------------------
package btne_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int MID     = (ENTRIES + 1) / 2;

  localparam int KIND_W  = 3;
  localparam int KEY_W   = 32;
  localparam int CHILD_W = 32;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 5;
  localparam int OCNT_W  = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_DELETE = 3'd4,
    KIND_INIT   = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_SPLIT_HDR = 3'd3,
    ST_SPLIT_ENT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    EM_DONE,
    EM_NOT_FOUND,
    EM_BAD_INDEX,
    EM_LOOKUP,
    EM_LOC_LEFT,
    EM_LOC_IDX,
    EM_SPLIT
  } emit_sel_t;

  typedef enum logic [2:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC,
    CNT_CLR,
    CNT_MID
  } cnt_op_t;

  typedef struct packed {
    logic      latch;
    logic      idx_inc;
    logic      idx_mid;
    logic      idx_index;
    logic      res_ld;
    logic      pos_ld;
    logic      shift_up;
    logic      shift_dn;
    logic      set_left;
    cnt_op_t   cnt_op;
    logic      emit;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_lt_cnt;
    logic key_le;
    logic key_lt;
    logic child_eq;
    logic left_eq;
    logic idx_end;
    logic full;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/btne_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btne_dp
// Node storage, scan pointer, shift logic and the result register.
// ----------------------------------------------------------------------------
module btne_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  btne_pkg::dp_cmd_t                cmd,
  output btne_pkg::dp_stat_t               stat,
  input  logic [btne_pkg::KEY_W-1:0]       in_key,
  input  logic [btne_pkg::CHILD_W-1:0]     in_child,
  input  logic [btne_pkg::INDEX_W-1:0]     in_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [btne_pkg::STAT_W-1:0]      out_status,
  output logic [btne_pkg::KEY_W-1:0]       out_key,
  output logic [btne_pkg::CHILD_W-1:0]     out_child,
  output logic [btne_pkg::POS_W-1:0]       out_position,
  output logic [btne_pkg::OCNT_W-1:0]      out_count,
  output logic                             out_last
);
  import btne_pkg::*;

  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [CHILD_W-1:0] child_mem [ENTRIES];
  logic [KEY_W-1:0]   key_q_r;
  logic [CHILD_W-1:0] child_q_r;
  logic [INDEX_W-1:0] index_q_r;
  logic [CHILD_W-1:0] left_r, left_nxt;
  logic [CHILD_W-1:0] res_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r;
  logic [CNT_W-1:0]   split_addr;
  logic [KEY_W-1:0]   scan_key, split_key;
  logic [CHILD_W-1:0] scan_child, split_child;
  logic               ovalid_r;
  logic [STAT_W-1:0]  ostat_r;
  logic [KEY_W-1:0]   okey_r;
  logic [CHILD_W-1:0] ochild_r;
  logic [POS_W-1:0]   opos_r;
  logic [OCNT_W-1:0]  ocnt_r;
  logic               olast_r;

  assign scan_key    = key_mem[idx_r[IDX_W-1:0]];
  assign scan_child  = child_mem[idx_r[IDX_W-1:0]];
  assign split_addr  = (idx_r < pos_r) ? idx_r : idx_r - 1'b1;
  assign split_key   = (idx_r == pos_r) ? key_q_r : key_mem[split_addr[IDX_W-1:0]];
  assign split_child = (idx_r == pos_r) ? child_q_r : child_mem[split_addr[IDX_W-1:0]];

  assign stat.idx_lt_cnt = idx_r < cnt_r;
  assign stat.key_le     = scan_key <= key_q_r;
  assign stat.key_lt     = scan_key < key_q_r;
  assign stat.child_eq   = scan_child == child_q_r;
  assign stat.left_eq    = left_r == child_q_r;
  assign stat.idx_end    = idx_r == CNT_W'(ENTRIES);
  assign stat.full       = cnt_r == CNT_W'(ENTRIES);
  assign stat.out_free   = !ovalid_r || out_ready;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.latch) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.idx_mid) begin
      idx_nxt = CNT_W'(MID);
    end else if (cmd.idx_index) begin
      idx_nxt = CNT_W'(index_q_r);
    end
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + 1'b1;
      CNT_DEC: cnt_nxt = cnt_r - 1'b1;
      CNT_CLR: cnt_nxt = '0;
      CNT_MID: cnt_nxt = CNT_W'(MID);
      default: cnt_nxt = cnt_r;
    endcase
    left_nxt = cmd.set_left ? child_q_r : left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      left_r   <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_q_r   <= in_key;
      child_q_r <= in_child;
      index_q_r <= in_index;
      res_r     <= left_r;
    end else if (cmd.res_ld) begin
      res_r <= scan_child;
    end
    if (cmd.pos_ld) begin
      pos_r <= idx_r;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.shift_up) begin
        if (CNT_W'(i) == pos_r) begin
          key_mem[i]   <= key_q_r;
          child_mem[i] <= child_q_r;
        end else if (CNT_W'(i) > pos_r) begin
          key_mem[i]   <= key_mem[(i > 0) ? i - 1 : 0];
          child_mem[i] <= child_mem[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.shift_dn) begin
        if (CNT_W'(i) >= idx_r && i < ENTRIES - 1) begin
          key_mem[i]   <= key_mem[(i < ENTRIES - 1) ? i + 1 : i];
          child_mem[i] <= child_mem[(i < ENTRIES - 1) ? i + 1 : i];
        end
      end
    end
    if (cmd.emit) begin
      ostat_r  <= ST_DONE;
      okey_r   <= '0;
      ochild_r <= '0;
      opos_r   <= '0;
      ocnt_r   <= OCNT_W'(cnt_r);
      olast_r  <= 1'b1;
      case (cmd.emit_sel)
        EM_NOT_FOUND: ostat_r <= ST_NOT_FOUND;
        EM_BAD_INDEX: ostat_r <= ST_BAD_INDEX;
        EM_LOOKUP:    ochild_r <= res_r;
        EM_LOC_LEFT:  opos_r <= '1;
        EM_LOC_IDX:   opos_r <= POS_W'(idx_r);
        EM_SPLIT: begin
          ostat_r  <= (idx_r == CNT_W'(MID)) ? ST_SPLIT_HDR : ST_SPLIT_ENT;
          okey_r   <= split_key;
          ochild_r <= split_child;
          ocnt_r   <= OCNT_W'(MID);
          olast_r  <= idx_r == CNT_W'(ENTRIES);
        end
        default: ostat_r <= ST_DONE;
      endcase
    end
  end

  assign out_valid    = ovalid_r;
  assign out_status   = ostat_r;
  assign out_key      = okey_r;
  assign out_child    = ochild_r;
  assign out_position = opos_r;
  assign out_count    = ocnt_r;
  assign out_last     = olast_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES)) else $error("entry count above capacity");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("result overwritten");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count did not advance");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_dn |-> stat.idx_lt_cnt) else $error("delete beyond count");
`endif

endmodule

// ===== rtl/btne_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btne_ctrl
// Operation sequencer: scans, shifts and result emission.
// ----------------------------------------------------------------------------
module btne_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [btne_pkg::KIND_W-1:0] in_kind,
  input  btne_pkg::dp_stat_t          stat,
  output btne_pkg::dp_cmd_t           cmd
);
  import btne_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK, S_INS, S_INS_DO, S_REM, S_LOC, S_DEL, S_DEL_DO,
    S_INIT, S_SPLIT, S_SPLIT_FIN, S_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  emit_sel_t sel_r, sel_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.cnt_op   = CNT_KEEP;
    cmd.emit_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_kind)
            KIND_LOOKUP: state_nxt = S_LK;
            KIND_INSERT: state_nxt = S_INS;
            KIND_REMOVE: state_nxt = S_REM;
            KIND_LOCATE: state_nxt = S_LOC;
            KIND_DELETE: state_nxt = S_DEL;
            KIND_INIT:   state_nxt = S_INIT;
            default: begin
              sel_nxt   = EM_DONE;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_LK: begin
        if (stat.idx_lt_cnt && stat.key_le) begin
          cmd.res_ld  = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          sel_nxt   = EM_LOOKUP;
          state_nxt = S_EMIT;
        end
      end
      S_INS: begin
        if (stat.idx_lt_cnt && stat.key_lt) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.pos_ld = 1'b1;
          if (stat.full) begin
            cmd.idx_mid = 1'b1;
            state_nxt   = S_SPLIT;
          end else begin
            state_nxt = S_INS_DO;
          end
        end
      end
      S_INS_DO: begin
        cmd.shift_up = 1'b1;
        cmd.cnt_op   = CNT_INC;
        sel_nxt      = EM_DONE;
        state_nxt    = S_EMIT;
      end
      S_REM: begin
        if (stat.idx_lt_cnt) begin
          if (stat.child_eq) begin
            cmd.shift_dn = 1'b1;
            cmd.cnt_op   = CNT_DEC;
            sel_nxt      = EM_DONE;
            state_nxt    = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          sel_nxt   = EM_NOT_FOUND;
          state_nxt = S_EMIT;
        end
      end
      S_LOC: begin
        if (stat.left_eq) begin
          sel_nxt   = EM_LOC_LEFT;
          state_nxt = S_EMIT;
        end else if (stat.idx_lt_cnt) begin
          if (stat.child_eq) begin
            sel_nxt   = EM_LOC_IDX;
            state_nxt = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          sel_nxt   = EM_NOT_FOUND;
          state_nxt = S_EMIT;
        end
      end
      S_DEL: begin
        cmd.idx_index = 1'b1;
        state_nxt     = S_DEL_DO;
      end
      S_DEL_DO: begin
        if (stat.idx_lt_cnt) begin
          cmd.shift_dn = 1'b1;
          cmd.cnt_op   = CNT_DEC;
          sel_nxt      = EM_DONE;
        end else begin
          sel_nxt = EM_BAD_INDEX;
        end
        state_nxt = S_EMIT;
      end
      S_INIT: begin
        cmd.set_left = 1'b1;
        cmd.cnt_op   = CNT_CLR;
        sel_nxt      = EM_DONE;
        state_nxt    = S_EMIT;
      end
      S_SPLIT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SPLIT;
          if (stat.idx_end) begin
            state_nxt = S_SPLIT_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SPLIT_FIN: begin
        cmd.shift_up = 1'b1;
        cmd.cnt_op   = CNT_MID;
        state_nxt    = S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= EM_DONE;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_split_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT_FIN) |-> $past(cmd.emit) && $past(stat.idx_end))
    else $error("split ended early");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_ready) else $error("accepted while busy");
  a_shift_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift_up && cmd.shift_dn)) else $error("conflicting shifts");
`endif

endmodule

// ===== rtl/btree_internal_node_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btree_internal_node_engine_top
// One B-tree internal node with lookup, insert/split, remove, locate, delete
// and init operations.
// ----------------------------------------------------------------------------
// The time from transfer to result is set by the scan, which reads one entry
// per cycle. A split emits ENTRIES - MID + 1 results at one per cycle while
// the output is free, then writes back the lower half. Throughput: one
// operation at a time; the next transfer is taken after the last result is
// registered. Reset clears the count, leftmost child and the result valid;
// entry storage is not cleared.
// ----------------------------------------------------------------------------
module btree_internal_node_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key[31:0], child[63:32], index[67:64]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // key_out[31:0], child_out[63:32],
                                  // position[68:64], count[73:69]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);
  import btne_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [POS_W-1:0]   o_pos;
  logic [OCNT_W-1:0]  o_cnt;
  logic [KEY_W-1:0]   o_key;
  logic [CHILD_W-1:0] o_child;

  btne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  btne_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_key       (in_tdata[31:0]),
    .in_child     (in_tdata[63:32]),
    .in_index     (in_tdata[67:64]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_tuser),
    .out_key      (o_key),
    .out_child    (o_child),
    .out_position (o_pos),
    .out_count    (o_cnt),
    .out_last     (out_tlast)
  );

  assign out_tdata = {6'd0, o_cnt, o_pos, o_child, o_key};

endmodule

// ===== bench/tb_btree_internal_node_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_btree_internal_node_engine_top
// Self-checking bench for the B-tree internal node engine. A behavioral copy
// of the node predicts every result, including split runs, and a monitor
// compares each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_btree_internal_node_engine_top;
  import btne_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] key_out;
    logic [31:0] child_out;
    logic [4:0]  position;
    logic [4:0]  count;
    logic        last;
  } node_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  logic [31:0]  node_keys [ENTRIES];
  logic [31:0]  node_children [ENTRIES];
  logic [31:0]  node_left;
  int           node_count;
  node_result_t expected_results[$];
  int           mismatches;
  bit           hold_off;
  bit           fast_mode;

  btree_internal_node_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic node_result_t make_result(status_t st, logic [31:0] k,
                                               logic [31:0] c, int pos, bit lst);
    node_result_t r;
    r.status = st;
    r.key_out = k;
    r.child_out = c;
    r.position = pos[4:0];
    r.count = node_count[4:0];
    r.last = lst;
    return r;
  endfunction

  task automatic drop_entry(int idx);
    for (int i = idx; i + 1 < node_count; i++) begin
      node_keys[i] = node_keys[i + 1];
      node_children[i] = node_children[i + 1];
    end
    node_count--;
  endtask

  task automatic predict_node_op(logic [2:0] kind, logic [31:0] key,
                                 logic [31:0] child, logic [3:0] index);
    logic [31:0] merged_keys [ENTRIES + 1];
    logic [31:0] merged_children [ENTRIES + 1];
    logic [31:0] found;
    int          slot;
    int          j;
    found = node_left;
    slot = -1;
    j = 0;
    case (kind)
      KIND_LOOKUP: begin
        for (int i = node_count - 1; i >= 0; i--)
          if (node_keys[i] <= key) begin
            found = node_children[i];
            break;
          end
        expected_results.push_back(make_result(ST_DONE, '0, found, 0, 1'b1));
      end
      KIND_INSERT: begin
        slot = 0;
        while (slot < node_count && node_keys[slot] < key) slot++;
        if (node_count < ENTRIES) begin
          for (int i = node_count; i > slot; i--) begin
            node_keys[i] = node_keys[i - 1];
            node_children[i] = node_children[i - 1];
          end
          node_keys[slot] = key;
          node_children[slot] = child;
          node_count++;
          expected_results.push_back(make_result(ST_DONE, '0, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i <= ENTRIES; i++) begin
            if (i == slot) begin
              merged_keys[i] = key;
              merged_children[i] = child;
            end else begin
              merged_keys[i] = node_keys[j];
              merged_children[i] = node_children[j];
              j++;
            end
          end
          for (int i = 0; i < MID; i++) begin
            node_keys[i] = merged_keys[i];
            node_children[i] = merged_children[i];
          end
          node_count = MID;
          expected_results.push_back(make_result(ST_SPLIT_HDR, merged_keys[MID],
            merged_children[MID], 0, MID + 1 > ENTRIES));
          for (int i = MID + 1; i <= ENTRIES; i++)
            expected_results.push_back(make_result(ST_SPLIT_ENT, merged_keys[i],
              merged_children[i], 0, i == ENTRIES));
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < node_count; i++)
          if (node_children[i] == child) begin
            slot = i;
            break;
          end
        if (slot >= 0) drop_entry(slot);
        expected_results.push_back(make_result(slot >= 0 ? ST_DONE : ST_NOT_FOUND,
          '0, '0, 0, 1'b1));
      end
      KIND_LOCATE: begin
        if (node_left == child) begin
          expected_results.push_back(make_result(ST_DONE, '0, '0, -1, 1'b1));
        end else begin
          for (int i = 0; i < node_count; i++)
            if (node_children[i] == child) begin
              slot = i;
              break;
            end
          expected_results.push_back(make_result(slot >= 0 ? ST_DONE : ST_NOT_FOUND,
            '0, '0, slot >= 0 ? slot : 0, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (index >= node_count) begin
          expected_results.push_back(make_result(ST_BAD_INDEX, '0, '0, 0, 1'b1));
        end else begin
          drop_entry(index);
          expected_results.push_back(make_result(ST_DONE, '0, '0, 0, 1'b1));
        end
      end
      KIND_INIT: begin
        node_left = child;
        node_count = 0;
        expected_results.push_back(make_result(ST_DONE, '0, '0, 0, 1'b1));
      end
      default: expected_results.push_back(make_result(ST_DONE, '0, '0, 0, 1'b1));
    endcase
  endtask

  task automatic send_node_op(logic [2:0] kind, logic [31:0] key,
                              logic [31:0] child, logic [3:0] index);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, index, child, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_node_op(kind, key, child, index);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic fill_node(int n, logic [31:0] key_base);
    for (int i = 0; i < n; i++)
      send_node_op(KIND_INSERT, key_base + $urandom_range(0, 40),
                   32'h1000 + $urandom_range(0, 63), 4'($urandom()));
  endtask

  task automatic test_directed();
    send_node_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'h0);
    send_node_op(KIND_LOCATE, 32'h0, 32'h0, 4'h0);
    send_node_op(KIND_DELETE, 32'h0, 32'h0, 4'h0);
    send_node_op(KIND_INIT, 32'h0, 32'hFFFF_FFFF, 4'hF);
    send_node_op(KIND_INSERT, 32'h0, 32'hAAAA_5555, 4'h0);
    send_node_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA, 4'h0);
    send_node_op(KIND_INSERT, 32'h0, 32'h1234_5678, 4'h0);
    send_node_op(KIND_LOOKUP, 32'h0, 32'h0, 4'h0);
    send_node_op(KIND_LOOKUP, 32'hFFFF_FFFE, 32'h0, 4'h0);
    send_node_op(KIND_LOCATE, 32'h0, 32'hFFFF_FFFF, 4'h0);
    send_node_op(KIND_LOCATE, 32'h0, 32'h5555_AAAA, 4'h0);
    send_node_op(KIND_LOCATE, 32'h0, 32'hDEAD_BEEF, 4'h0);
    send_node_op(KIND_REMOVE, 32'h0, 32'hFFFF_FFFF, 4'h0);
    send_node_op(KIND_REMOVE, 32'h0, 32'hAAAA_5555, 4'h0);
    send_node_op(KIND_DELETE, 32'h0, 32'h0, 4'hF);
    send_node_op(KIND_DELETE, 32'h0, 32'h0, 4'h1);
    send_node_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_node_op(3'd7, 32'h0, 32'h0, 4'h0);
    send_node_op(KIND_INIT, 32'h0, 32'h0, 4'h0);
    fill_node(ENTRIES, 32'h100);
    send_node_op(KIND_INSERT, 32'h0, 32'hCAFE_0001, 4'h0);
  endtask

  task automatic test_random_ops();
    logic [2:0] kind;
    for (int n = 0; n < 35; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_node_op(KIND_INIT, 32'h0, rand_word(), 4'($urandom()));
        fill_node($urandom_range(ENTRIES - 4, ENTRIES), $urandom_range(0, 3) == 0 ?
                  32'hFFFF_FF00 : 32'h0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: kind = KIND_INSERT;
        3, 4: kind = KIND_LOOKUP;
        5: kind = KIND_REMOVE;
        6: kind = KIND_LOCATE;
        7: kind = KIND_DELETE;
        8: kind = $urandom_range(0, 19) == 0 ? KIND_INIT : KIND_LOOKUP;
        default: kind = 3'($urandom_range(0, 7));
      endcase
      send_node_op(kind, $urandom_range(0, 1) ? rand_word() : $urandom_range(0, 80),
                   $urandom_range(0, 1) ? rand_word() : 32'h1000 + $urandom_range(0, 63),
                   4'($urandom()));
    end
  endtask

  task automatic test_back_pressure();
    fast_mode = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        send_node_op(KIND_INIT, 32'h0, 32'h77, 4'h0);
        fill_node(ENTRIES, 32'h40);
        send_node_op(KIND_INSERT, 32'h45, 32'h99, 4'h0);
      end
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    fast_mode = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7) || fast_mode;
  end

  always @(posedge clk) begin
    node_result_t got;
    node_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.key_out = out_tdata[31:0];
      got.child_out = out_tdata[63:32];
      got.position = out_tdata[68:64];
      got.count = out_tdata[73:69];
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** btree_internal_node_engine_top: FAILED **");
    $finish;
  end

  initial begin
    node_left = '0;
    node_count = 0;
    mismatches = 0;
    hold_off = 1'b0;
    fast_mode = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_random_ops();
    in_tvalid <= 1'b0;
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("** btree_internal_node_engine_top: PASSED **");
    else
      $display("** btree_internal_node_engine_top: FAILED **");
    $finish;
  end
endmodule
